// ===== hw/rtl/cndt_pkg.sv =====
// Shared types and constants for the call nesting depth tracker.
// No dependencies; used by every module under hw/rtl.
package cndt_pkg;

  localparam int TIME_W      = 48;
  localparam int END_W       = TIME_W + 1;
  localparam int ID_W        = 32;
  localparam int DEPTH_OUT_W = 7;
  localparam int DEPTH_SAT   = 127;
  localparam int STACK_DEPTH_DEFAULT = 64;

  // One open interval: its end time and the index of the event that opened it.
  typedef struct packed {
    logic [END_W-1:0] end_time;
    logic [ID_W-1:0]  event_id;
  } entry_t;

  // Shift command for the row of stack cells.
  typedef struct packed {
    logic push;
    logic pop;
  } stk_op_t;

  typedef enum logic {
    S_IDLE,
    S_POP
  } state_t;

endpackage

// ===== hw/rtl/cndt_cell.sv =====
// One stack cell of the nesting depth tracker: holds a single open interval.
// Depends on cndt_pkg (entry_t, stk_op_t).
module cndt_cell (
  input  logic              clk,
  input  cndt_pkg::stk_op_t op,
  input  cndt_pkg::entry_t  from_above,
  input  cndt_pkg::entry_t  from_below,
  output cndt_pkg::entry_t  entry
);

  // Push moves entries away from the top, pop moves them towards it.
  always_ff @(posedge clk) begin
    if (op.push) begin
      entry <= from_above;
    end else if (op.pop) begin
      entry <= from_below;
    end
  end

endmodule

// ===== hw/rtl/cndt_chain.sv =====
// Row of stack cells with the top of stack at cell 0.
// Depends on cndt_pkg and cndt_cell.
module cndt_chain #(
  parameter int STACK_DEPTH = cndt_pkg::STACK_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  cndt_pkg::stk_op_t op,
  input  cndt_pkg::entry_t  push_entry,
  output cndt_pkg::entry_t  top_entry
);

  cndt_pkg::entry_t cells [STACK_DEPTH];

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    cndt_pkg::entry_t above;
    cndt_pkg::entry_t below;

    if (i == 0) begin : g_top
      assign above = push_entry;
    end else begin : g_inner_a
      assign above = cells[i-1];
    end

    // The bottom cell has nothing beneath it; hold its own value on a pop.
    if (i == STACK_DEPTH - 1) begin : g_bottom
      assign below = cells[i];
    end else begin : g_inner_b
      assign below = cells[i+1];
    end

    cndt_cell u_cell (
      .clk        (clk),
      .op         (op),
      .from_above (above),
      .from_below (below),
      .entry      (cells[i])
    );
  end

  assign top_entry = cells[0];

endmodule

// ===== hw/rtl/call_nesting_depth_tracker.sv =====
// Call nesting depth tracker: top level with sequencer and result register.
// Depends on cndt_pkg and cndt_chain (which instantiates cndt_cell).
// Sequence: a request is taken in idle; the pop state then drops closed entries, one pop per cycle,
// then registers the result once the result register is free; a new request waits for idle.
// Reset: clears stack size, running maximum, sequencer state and result valid.
// Stack cells are not cleared; only entries below the stack size are ever read.
module call_nesting_depth_tracker #(
  parameter int STACK_DEPTH = cndt_pkg::STACK_DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  // request channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               start_of_thread,
  input  logic [cndt_pkg::TIME_W-1:0]        start_time,
  input  logic [cndt_pkg::TIME_W-1:0]        duration,
  input  logic [cndt_pkg::ID_W-1:0]          event_index,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [cndt_pkg::DEPTH_OUT_W-1:0]   nest_depth,
  output logic                               has_parent,
  output logic [cndt_pkg::ID_W-1:0]          parent_index,
  output logic [cndt_pkg::DEPTH_OUT_W-1:0]   thread_max_depth,
  output logic                               stack_overflow
);

  localparam int SW = $clog2(STACK_DEPTH + 1);

  // ------------------------------------------------------------------
  // Registers
  // ------------------------------------------------------------------
  cndt_pkg::state_t                state;
  cndt_pkg::state_t                state_next;
  logic [SW-1:0]                   size;
  logic [SW-1:0]                   peak_depth;
  logic [cndt_pkg::TIME_W-1:0]     start_q;
  logic [cndt_pkg::TIME_W-1:0]     dur_q;
  logic [cndt_pkg::ID_W-1:0]       id_q;

  // ------------------------------------------------------------------
  // Control
  // ------------------------------------------------------------------
  logic             accept;
  logic             pop_now;
  logic             finish;
  logic             push_now;
  logic             full;
  logic             wants_push;
  logic [SW-1:0]    max_next;
  cndt_pkg::stk_op_t op;
  cndt_pkg::entry_t  top_entry;
  cndt_pkg::entry_t  push_entry;

  assign accept     = in_valid && in_ready;
  assign full       = (32'(size) >= STACK_DEPTH);
  assign wants_push = (dur_q != '0);
  assign max_next   = (size > peak_depth) ? size : peak_depth;

  // Next state: take a request in idle, then pop until the stack is empty or the top
  // entry still encloses the start, and the result register is free.
  always_comb begin
    state_next = state;
    case (state)
      cndt_pkg::S_IDLE: begin
        if (accept) state_next = cndt_pkg::S_POP;
      end
      cndt_pkg::S_POP: begin
        if (finish) state_next = cndt_pkg::S_IDLE;
      end
      default: state_next = cndt_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ready = 1'b0;
    pop_now  = 1'b0;
    finish   = 1'b0;
    case (state)
      cndt_pkg::S_IDLE: begin
        in_ready = 1'b1;
      end
      cndt_pkg::S_POP: begin
        // Drop a closed interval: its end is at or before this start.
        pop_now = (size != '0) && (top_entry.end_time <= {1'b0, start_q});
        finish  = !pop_now && (!out_valid || out_ready);
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign push_now = finish && wants_push && !full;

  assign op.push = push_now;
  assign op.pop  = pop_now;

  // End time is formed one bit wider so it cannot wrap.
  assign push_entry.end_time = {1'b0, start_q} + {1'b0, dur_q};
  assign push_entry.event_id = id_q;

  cndt_chain #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_chain (
    .clk        (clk),
    .op         (op),
    .push_entry (push_entry),
    .top_entry  (top_entry)
  );

  // ------------------------------------------------------------------
  // State and counters
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= cndt_pkg::S_IDLE;
      size       <= '0;
      peak_depth <= '0;
    end else begin
      state <= state_next;
      if (accept && start_of_thread) begin
        // New thread: forget every open interval and the running maximum.
        size       <= '0;
        peak_depth <= '0;
      end else begin
        if (pop_now) begin
          size <= size - SW'(1);
        end else if (push_now) begin
          size <= size + SW'(1);
        end
        if (finish) begin
          peak_depth <= max_next;
        end
      end
    end
  end

  // Hold the request fields for the whole pop sequence.
  always_ff @(posedge clk) begin
    if (accept) begin
      start_q <= start_time;
      dur_q   <= duration;
      id_q    <= event_index;
    end
  end

  // ------------------------------------------------------------------
  // Result register
  // ------------------------------------------------------------------
  logic [cndt_pkg::DEPTH_OUT_W-1:0] depth_sat;
  logic [cndt_pkg::DEPTH_OUT_W-1:0] max_sat;

  // Saturate only matters for stacks deeper than the output field can count.
  assign depth_sat = (32'(size) > cndt_pkg::DEPTH_SAT)
                   ? cndt_pkg::DEPTH_OUT_W'(cndt_pkg::DEPTH_SAT)
                   : cndt_pkg::DEPTH_OUT_W'(size);
  assign max_sat   = (32'(max_next) > cndt_pkg::DEPTH_SAT)
                   ? cndt_pkg::DEPTH_OUT_W'(cndt_pkg::DEPTH_SAT)
                   : cndt_pkg::DEPTH_OUT_W'(max_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      nest_depth       <= depth_sat;
      has_parent       <= (size != '0);
      parent_index     <= (size != '0) ? top_entry.event_id : '0;
      thread_max_depth <= max_sat;
      stack_overflow   <= wants_push && full;
    end
  end

`ifndef SYNTHESIS
  a_finish_to_idle: assert property (@(posedge clk) disable iff (rst)
    finish |=> (state == cndt_pkg::S_IDLE) && out_valid)
    else $error("result not presented after sequence end");

  a_thread_clear: assert property (@(posedge clk) disable iff (rst)
    accept && start_of_thread |=> (size == '0) && (peak_depth == '0))
    else $error("thread start did not clear the stack");

  a_parent_depth: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (has_parent == (nest_depth != '0)))
    else $error("parent flag disagrees with depth");

  a_max_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (thread_max_depth >= nest_depth))
    else $error("running maximum below current depth");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    finish && wants_push && full |=> stack_overflow && (32'(size) == STACK_DEPTH))
    else $error("overflow reported without a full stack");
`endif

endmodule
